/* design/pscct_pkg.sv */
// Package for the per-source connection count table.
// Holds sizes, op codes and sequencer state codes; no dependencies.
package pscct_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    // entry word: addr_hi, addr_lo, count, stamp
    localparam int ENTRY_W = 64 + 64 + 16 + 32;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_SWEEP = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [15:0] INTERVAL_RESET = 16'd600;
    localparam logic [8:0]  LIMIT_RESET    = 9'd192;

    localparam logic [0:0] REG_INTERVAL = 1'd0;
    localparam logic [0:0] REG_LIMIT    = 1'd1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SWCHK  = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;
endpackage

/* design/pscct_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module pscct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* design/per_source_connection_count_table_unit.sv */
// Per-source connection count table, top level.
// A check walks the table one entry a cycle to find the address and a free
// slot, then updates the entry; a sweep, when due, walks it again. Clear and
// unused ops go straight to the result. One request at a time.
// Reset (rst_n, async, active low) clears valid bits, counters and total, and
// sets the configuration registers to their reset values; entry contents are
// only read behind a valid bit. Uses pscct_pkg and pscct_ram.
module per_source_connection_count_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic        addr_present,
    input  logic signed [15:0] delta,
    input  logic [31:0] now_time,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] count,
    output logic signed [31:0] total_open,
    output logic [8:0]  entries_used,
    output logic        table_full,
    output logic        swept,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = pscct_pkg::IDX_W;
    localparam int CW = pscct_pkg::CNT_W;
    localparam int TABLE_BITS = pscct_pkg::TABLE_ENTRIES;

    // configuration registers
    logic [15:0] interval_reg;
    logic [8:0]  limit_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= pscct_pkg::INTERVAL_RESET;
            limit_reg    <= pscct_pkg::LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                pscct_pkg::REG_INTERVAL: interval_reg <= pwdata[15:0];
                pscct_pkg::REG_LIMIT:    limit_reg    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            pscct_pkg::REG_INTERVAL: prdata = {16'd0, interval_reg};
            default:                 prdata = {23'd0, limit_reg};
        endcase
    end

    // state
    logic [2:0]  state_reg;
    logic [TABLE_BITS-1:0] valid_reg;
    logic [CW-1:0] used_reg;
    logic signed [31:0] total_reg;
    logic [31:0] last_reg;
    logic        started_reg;
    // walk index: one extra bit marks the end of the table
    logic [IW:0] idx_reg;
    logic [IW-1:0] hit_reg;
    logic        hit_found_reg;
    logic [IW-1:0] free_reg;
    logic        free_found_reg;
    logic        rd_pending_reg;
    // request held while it is worked on
    logic [63:0] ahi_reg;
    logic [63:0] alo_reg;
    logic signed [15:0] delta_reg;
    logic [31:0] now_reg;
    // result
    logic signed [15:0] res_reg;
    logic        full_reg;
    logic        swept_reg;
    logic        out_valid_reg;

    // table memory
    logic                           ram_we;
    logic [IW-1:0]                  ram_addr;
    logic [pscct_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [pscct_pkg::ENTRY_W-1:0]  ram_rdata;

    pscct_ram #(
        .WIDTH(pscct_pkg::ENTRY_W),
        .DEPTH(pscct_pkg::TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    logic [63:0] rd_hi;
    logic [63:0] rd_lo;
    logic signed [15:0] rd_cnt;
    logic [31:0] rd_stamp;
    assign {rd_hi, rd_lo, rd_cnt, rd_stamp} = ram_rdata;

    // the entry whose read data is now on ram_rdata
    logic [IW-1:0] prev_idx;
    assign prev_idx = idx_reg[IW-1:0] - IW'(1);
    logic prev_valid;
    assign prev_valid = valid_reg[prev_idx];

    assign in_stall = (state_reg != pscct_pkg::ST_IDLE) || out_valid_reg;
    logic accept;
    assign accept = in_valid && !in_stall;

    // saturating count update
    logic signed [16:0] cnt_sum;
    logic signed [15:0] cnt_sat;
    assign cnt_sum = 17'(rd_cnt) + 17'(delta_reg);
    always_comb
    begin
        if (cnt_sum > 17'sd32767)
            cnt_sat = 16'sh7fff;
        else if (cnt_sum < -17'sd32768)
            cnt_sat = 16'sh8000;
        else
            cnt_sat = cnt_sum[15:0];
    end

    logic signed [32:0] tot_sum;
    logic signed [31:0] tot_sat;
    assign tot_sum = 33'(total_reg) + 33'(delta_reg);
    always_comb
    begin
        if (tot_sum > 33'sd2147483647)
            tot_sat = 32'sh7fffffff;
        else if (tot_sum < -33'sd2147483648)
            tot_sat = 32'sh80000000;
        else
            tot_sat = tot_sum[31:0];
    end

    // sweep due test, 33-bit time sums
    logic [32:0] half_sum;
    logic [32:0] full_sum;
    logic        sweep_due;
    assign half_sum  = {1'b0, last_reg} + 33'(interval_reg[15:1]);
    assign full_sum  = {1'b0, last_reg} + 33'(interval_reg);
    assign sweep_due = (half_sum < {1'b0, now_reg})
                       && ((full_sum < {1'b0, now_reg}) || (9'(used_reg) > limit_reg));

    // entry expiry: count not positive and stamp + interval <= now
    logic expired;
    assign expired = (rd_cnt <= 16'sd0)
                     && !(({1'b0, rd_stamp} + 33'(interval_reg)) > {1'b0, now_reg});

    logic walk_end;
    assign walk_end = idx_reg == (IW + 1)'(pscct_pkg::TABLE_ENTRIES);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg[IW-1:0];
        ram_wdata = {ahi_reg, alo_reg, delta_reg, now_reg};
        if (state_reg == pscct_pkg::ST_UPDATE)
        begin
            if (hit_found_reg)
            begin
                ram_addr  = hit_reg;
                ram_we    = rd_pending_reg && (delta_reg != 16'sd0);
                ram_wdata = {rd_hi, rd_lo, cnt_sat, now_reg};
            end
            else
            begin
                ram_addr = free_reg;
                ram_we   = (delta_reg > 16'sd0) && free_found_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pscct_pkg::ST_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            total_reg      <= '0;
            last_reg       <= '0;
            started_reg    <= 1'b0;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                pscct_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        ahi_reg        <= addr_hi;
                        alo_reg        <= addr_lo;
                        delta_reg      <= delta;
                        now_reg        <= now_time;
                        res_reg        <= '0;
                        full_reg       <= 1'b0;
                        swept_reg      <= 1'b0;
                        idx_reg        <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        rd_pending_reg <= 1'b0;
                        if ((op == pscct_pkg::OP_CHECK && addr_present)
                            || op == pscct_pkg::OP_SWEEP)
                        begin
                            if (!started_reg)
                            begin
                                started_reg <= 1'b1;
                                last_reg    <= now_time;
                            end
                        end
                        if (op == pscct_pkg::OP_CHECK && addr_present)
                            state_reg <= pscct_pkg::ST_SCAN;
                        else if (op == pscct_pkg::OP_SWEEP)
                            state_reg <= pscct_pkg::ST_SWCHK;
                        else
                        begin
                            if (op == pscct_pkg::OP_CLEAR)
                            begin
                                valid_reg <= '0;
                                used_reg  <= '0;
                                total_reg <= '0;
                            end
                            state_reg <= pscct_pkg::ST_DONE;
                        end
                    end
                end
                pscct_pkg::ST_SCAN:
                begin
                    // read issued at idx, compared in the cycle after
                    if (rd_pending_reg && prev_valid && !hit_found_reg
                        && rd_hi == ahi_reg && rd_lo == alo_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_reg       <= prev_idx;
                    end
                    if (!walk_end && !valid_reg[idx_reg[IW-1:0]] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_reg       <= idx_reg[IW-1:0];
                    end
                    if (walk_end)
                    begin
                        rd_pending_reg <= 1'b0;
                        state_reg      <= pscct_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        rd_pending_reg <= 1'b1;
                        idx_reg        <= idx_reg + (IW + 1)'(1);
                    end
                end
                pscct_pkg::ST_UPDATE:
                begin
                    // hit: reads the entry, then writes it once the read data is back
                    if (hit_found_reg && !rd_pending_reg)
                        rd_pending_reg <= 1'b1;
                    else
                    begin
                        rd_pending_reg <= 1'b0;
                        if (hit_found_reg)
                        begin
                            if (delta_reg != 16'sd0)
                            begin
                                res_reg   <= cnt_sat;
                                total_reg <= tot_sat;
                            end
                            else
                                res_reg <= rd_cnt;
                        end
                        else if (delta_reg > 16'sd0)
                        begin
                            if (free_found_reg)
                            begin
                                valid_reg[free_reg] <= 1'b1;
                                used_reg  <= used_reg + CW'(1);
                                total_reg <= tot_sat;
                                res_reg   <= delta_reg;
                            end
                            else
                                full_reg <= 1'b1;
                        end
                        state_reg <= pscct_pkg::ST_SWCHK;
                    end
                end
                pscct_pkg::ST_SWCHK:
                begin
                    idx_reg        <= '0;
                    rd_pending_reg <= 1'b0;
                    if (sweep_due)
                    begin
                        last_reg  <= now_reg;
                        state_reg <= pscct_pkg::ST_SWEEP;
                    end
                    else
                        state_reg <= pscct_pkg::ST_DONE;
                end
                pscct_pkg::ST_SWEEP:
                begin
                    if (rd_pending_reg && prev_valid && expired)
                    begin
                        valid_reg[prev_idx] <= 1'b0;
                        used_reg  <= used_reg - CW'(1);
                        swept_reg <= 1'b1;
                    end
                    if (walk_end)
                        state_reg <= pscct_pkg::ST_DONE;
                    else
                    begin
                        rd_pending_reg <= 1'b1;
                        idx_reg        <= idx_reg + (IW + 1)'(1);
                    end
                end
                pscct_pkg::ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= pscct_pkg::ST_IDLE;
                end
                default: state_reg <= pscct_pkg::ST_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign count        = res_reg;
    assign total_open   = total_reg;
    assign entries_used = 9'(used_reg);
    assign table_full   = full_reg;
    assign swept        = swept_reg;
endmodule
